/* sv/tsb_pkg.sv */
// texture sampler package: register indexes, request codes and fixed-point constants
// no dependencies; imported by the sampler top level
package tsb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_EXPOSURE     = 3'd2;
  localparam logic [2:0] REG_BORDER_MODE  = 3'd3;
  localparam logic [2:0] REG_FILTER_MODE  = 3'd4;

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // border and filter codes
  localparam logic BORDER_CLAMP  = 1'b0;
  localparam logic BORDER_REPEAT = 1'b1;
  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  // Q16.16 constants
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  // one stored texel
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } texel_t;

endpackage

/* sv/texture_sampler_bilinear_unit.sv */
// texture sampler top level: texel store, coordinate pipeline, fetch sequencer, blend
// depends on tsb_pkg
//
// A request is taken when start is high and busy is low. A texel write or a nearest
// sample makes one access to the single texel memory port, a bilinear sample four
// texel reads (one texel read per cycle); the rest run at one per cycle while no
// bilinear sample holds the port. Requests are still taken during those reads until
// both coordinate stages are full. A sample's result passes the scaling, border,
// sequencer, read, column-sum, weight, exposure and output registers and shows on
// out_valid for one cycle only; the receiver cannot stall it. Requests complete in
// order, so a sample sees every texel written by earlier requests. Texels that were
// never written read back as undefined values. Configuration is to be written only
// while idle, by the user; the block itself does not enforce it.
module texture_sampler_bilinear_unit #(
  parameter int MAX_SIDE     = 256,
  parameter int CHANNEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [7:0]  in_texel_x,
  input  logic [7:0]  in_texel_y,
  input  logic [15:0] in_texel_red,
  input  logic [15:0] in_texel_green,
  input  logic [15:0] in_texel_blue,
  input  logic [31:0] in_coord_u,
  input  logic [31:0] in_coord_v,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic [15:0] out_color_red,
  output logic [15:0] out_color_green,
  output logic [15:0] out_color_blue
);
  import tsb_pkg::*;

  localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH = 1 << (2 * AW);
  localparam logic [32:0] CHAN_MAX = (33'd1 << CHANNEL_BITS) - 33'd1;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [15:0]   f;
  } axis_t;

  // one axis: texel pair and fraction from scaled coordinate
  function automatic axis_t axis_fix(input logic signed [43:0] s, input logic [24:0] w,
                                     input logic [8:0] n, input logic bil, input logic rep);
    axis_t r;
    logic signed [43:0] t;
    logic signed [27:0] c0;
    logic signed [28:0] c1;
    logic signed [25:0] tw;
    logic signed [9:0]  cw;
    logic [9:0] nm1;
    logic [9:0] wa;
    logic [9:0] wb;
    logic [9:0] ka;
    logic [9:0] kb;
    t   = bil ? s - 44'sd32768 : s;
    c0  = t[43:16];
    c1  = {c0[27], c0} + 29'sd1;
    tw  = $signed({1'b0, w}) - (bil ? 26'sd32768 : 26'sd0);
    cw  = tw[25:16];
    nm1 = {1'b0, n} - 10'd1;
    // repeat: fraction product already reduced modulo the side
    wa  = (cw < 0) ? nm1 : cw;
    wb  = (cw < 0) ? 10'd0 : ((cw + 10'sd1 == $signed({1'b0, n})) ? 10'd0 : cw + 10'd1);
    // clamp to edge
    ka  = (c0 < 0) ? 10'd0 : ((c0 > $signed({18'd0, nm1})) ? nm1 : c0[9:0]);
    kb  = (c1 < 0) ? 10'd0 : ((c1 > $signed({19'd0, nm1})) ? nm1 : c1[9:0]);
    r.a = rep ? wa[AW-1:0] : ka[AW-1:0];
    r.b = rep ? wb[AW-1:0] : kb[AW-1:0];
    r.f = bil ? t[15:0] : 16'd0;
    return r;
  endfunction

  // configuration registers
  logic [8:0]  width_r, height_r;
  logic [15:0] gain_r;
  logic        border_r, filter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      gain_r   <= 16'd256;
      border_r <= BORDER_REPEAT;
      filter_r <= FILTER_BILINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[8:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[8:0];
        REG_EXPOSURE:     gain_r   <= cfg_wdata;
        REG_BORDER_MODE:  border_r <= cfg_wdata[0];
        REG_FILTER_MODE:  filter_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective image size
  logic [8:0] n_w, n_h;
  always_comb begin
    n_w = (width_r == 9'd0) ? 9'd1 : width_r;
    if (32'(width_r) > MAX_SIDE) n_w = 9'(MAX_SIDE);
    n_h = (height_r == 9'd0) ? 9'd1 : height_r;
    if (32'(height_r) > MAX_SIDE) n_h = 9'(MAX_SIDE);
  end

  // pipeline control
  logic v1_r, v2_r, seq_v_r;
  logic [1:0] cnt_r, last_r;
  logic seq_last, stall2, move1, adv2, accept;

  assign seq_last = seq_v_r && (cnt_r == last_r);
  assign stall2   = seq_v_r && !seq_last;
  assign move1    = v1_r && !(v2_r && stall2);
  assign adv2     = v2_r && !stall2;
  assign busy     = v1_r && v2_r && stall2;
  assign accept   = start && !busy;

  // stage 1: coordinate scaling
  logic               s1_wr_r;
  logic [7:0]         s1_x_r, s1_y_r;
  texel_t             s1_tex_r;
  logic signed [43:0] s1_su_r, s1_sv_r;
  logic [24:0]        s1_wu_r, s1_wv_r;
  logic signed [32:0] vf;
  logic [15:0]        vf_lo;

  // flipped v, one minus v in Q16.16
  assign vf    = 33'sh10000 - $signed({in_coord_v[31], in_coord_v});
  assign vf_lo = 16'd0 - in_coord_v[15:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r  <= (in_req_type == REQ_WRITE);
      s1_x_r   <= in_texel_x;
      s1_y_r   <= in_texel_y;
      s1_tex_r <= '{red: in_texel_red, green: in_texel_green, blue: in_texel_blue};
      s1_su_r  <= 44'($signed(in_coord_u) * $signed({1'b0, n_w}));
      s1_sv_r  <= 44'(vf * $signed({1'b0, n_h}));
      s1_wu_r  <= 25'(in_coord_u[15:0] * n_w);
      s1_wv_r  <= 25'(vf_lo * n_h);
    end
  end

  // stage 2: border handling and texel addresses
  logic          s2_wr_r, s2_near_r, s2_inr_r;
  logic [AW-1:0] s2_wx_r, s2_wy_r;
  texel_t        s2_tex_r;
  axis_t         s2_u_r, s2_v_r;

  always_ff @(posedge clk) begin
    if (move1) begin
      s2_wr_r   <= s1_wr_r;
      s2_near_r <= (filter_r == FILTER_NEAREST);
      s2_inr_r  <= (32'(s1_x_r) < MAX_SIDE) && (32'(s1_y_r) < MAX_SIDE);
      s2_wx_r   <= AW'(s1_x_r);
      s2_wy_r   <= AW'(s1_y_r);
      s2_tex_r  <= s1_tex_r;
      s2_u_r    <= axis_fix(s1_su_r, s1_wu_r, n_w, filter_r == FILTER_BILINEAR,
                            border_r == BORDER_REPEAT);
      s2_v_r    <= axis_fix(s1_sv_r, s1_wv_r, n_h, filter_r == FILTER_BILINEAR,
                            border_r == BORDER_REPEAT);
    end
  end

  // fetch sequencer state
  logic          sq_wr_r, sq_inr_r;
  logic [AW-1:0] sq_wx_r, sq_wy_r;
  texel_t        sq_tex_r;
  axis_t         sq_u_r, sq_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      seq_v_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      if (accept) v1_r <= 1'b1;
      else if (move1) v1_r <= 1'b0;
      if (move1) v2_r <= 1'b1;
      else if (adv2) v2_r <= 1'b0;
      if (adv2) begin
        seq_v_r <= 1'b1;
        cnt_r   <= 2'd0;
      end else if (seq_last) begin
        seq_v_r <= 1'b0;
      end else if (seq_v_r) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      last_r   <= (s2_wr_r || s2_near_r) ? 2'd0 : 2'd3;
      sq_wr_r  <= s2_wr_r;
      sq_inr_r <= s2_inr_r;
      sq_wx_r  <= s2_wx_r;
      sq_wy_r  <= s2_wy_r;
      sq_tex_r <= s2_tex_r;
      sq_u_r   <= s2_u_r;
      sq_v_r   <= s2_v_r;
    end
  end

  // texel address for the current read: a(xa,ya) b(xa,yb) c(xb,ya) d(xb,yb)
  logic [AW-1:0]   rd_x, rd_y;
  logic [2*AW-1:0] mem_addr;
  assign rd_x     = cnt_r[1] ? sq_u_r.b : sq_u_r.a;
  assign rd_y     = cnt_r[0] ? sq_v_r.b : sq_v_r.a;
  assign mem_addr = sq_wr_r ? {sq_wy_r, sq_wx_r} : {rd_y, rd_x};

  // texel memory, one port
  texel_t mem [DEPTH];
  texel_t mem_q_r;

  always_ff @(posedge clk) begin
    if (seq_v_r && sq_wr_r && sq_inr_r) mem[mem_addr] <= sq_tex_r;
    mem_q_r <= mem[mem_addr];
  end

  // read tag, aligned with read data
  logic        rd_v_r, rd_fin_r;
  logic [1:0]  rd_idx_r;
  logic [15:0] rd_fu_r, rd_fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rd_v_r <= 1'b0;
    else rd_v_r <= seq_v_r && !sq_wr_r;
    rd_fin_r <= seq_last;
    rd_idx_r <= cnt_r;
    rd_fu_r  <= sq_u_r.f;
    rd_fv_r  <= sq_v_r.f;
  end

  // column sums: col0 = a*gv + b*fv, col1 = c*gv + d*fv
  logic [2:0][15:0] q_ch;
  logic [16:0]      wsel;
  logic [2:0][31:0] prod;
  logic [2:0][31:0] col0_r, col1_r;
  logic             bl_v_r;
  logic [15:0]      bl_fu_r;

  assign q_ch = {mem_q_r.red, mem_q_r.green, mem_q_r.blue};
  assign wsel = rd_idx_r[0] ? {1'b0, rd_fv_r} : ONE_Q16 - {1'b0, rd_fv_r};

  always_comb begin
    for (int c = 0; c < 3; c++) prod[c] = 32'(q_ch[c] * wsel);
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      for (int c = 0; c < 3; c++) begin
        case (rd_idx_r)
          2'd0: begin
            col0_r[c] <= prod[c];
            col1_r[c] <= 32'd0;
          end
          2'd1: col0_r[c] <= col0_r[c] + prod[c];
          2'd2: col1_r[c] <= prod[c];
          default: col1_r[c] <= col1_r[c] + prod[c];
        endcase
      end
    end
    if (rd_v_r && rd_fin_r) bl_fu_r <= rd_fu_r;
  end

  // horizontal weights
  logic [2:0][48:0] m0_r, m1_r;
  logic             b_v_r;
  logic [16:0]      gu;
  assign gu = ONE_Q16 - {1'b0, bl_fu_r};

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      m0_r[c] <= 49'(gu * col0_r[c]);
      m1_r[c] <= 49'(bl_fu_r * col1_r[c]);
    end
  end

  // blended color times exposure
  logic [2:0][49:0] bsum;
  logic [2:0][31:0] ex_r;
  logic             c_v_r;

  always_comb begin
    for (int c = 0; c < 3; c++) bsum[c] = {1'b0, m0_r[c]} + {1'b0, m1_r[c]};
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) ex_r[c] <= bsum[c][47:32] * gain_r;
  end

  // saturate and drive result
  logic [2:0][15:0] sat;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat[c] = ({9'd0, ex_r[c][31:8]} > CHAN_MAX) ? CHAN_MAX[15:0] : ex_r[c][23:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_v_r    <= 1'b0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      bl_v_r    <= rd_v_r && rd_fin_r;
      b_v_r     <= bl_v_r;
      c_v_r     <= b_v_r;
      out_valid <= c_v_r;
    end
    out_color_red   <= sat[2];
    out_color_green <= sat[1];
    out_color_blue  <= sat[0];
  end

endmodule

/* sv/tsb_checker.sv */
// port-level checks for the texture sampler
// no package needed; bound to texture_sampler_bilinear_unit
module tsb_port_checks (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // reset leaves the block ready
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  // reset drops any pending result
  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  // busy only follows a taken request or continues
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> ($past(start && !busy) || $past(busy)))
    else $error("busy without a request");

  // no result in the first cycles after reset
  a_result_latency: assert property (@(posedge clk)
    !rst_n |=> ##1 !out_valid)
    else $error("result too soon after reset");

endmodule

bind texture_sampler_bilinear_unit tsb_port_checks u_tsb_port_checks (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
